>>> rtl/sliding_window_rate_limiter_core_assert.svh
// Assertion macros for the rate limiter core
`ifndef SLIDING_WINDOW_RATE_LIMITER_CORE_ASSERT_SVH
`define SLIDING_WINDOW_RATE_LIMITER_CORE_ASSERT_SVH
// implication checked every clock, quiet in reset
`define SWRL_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define SWRL_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> rtl/swrl_pkg.sv
// ---------------------------------------------------------------------------
// swrl_pkg
// Types and constants shared by the rate limiter core.
// ---------------------------------------------------------------------------
package swrl_pkg;
    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int TIME_BITS_DEF   = 40;

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_WAIT   = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EXPIRE = 2'd3;

    localparam logic CFG_RATE = 1'b0;
    localparam logic CFG_WIN  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDW, S_DIVA, S_EXCHK, S_PUSH, S_DIVP, S_PACE, S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;
endpackage

>>> rtl/swrl_div.sv
// ---------------------------------------------------------------------------
// swrl_div
// Shared restoring divider: 64 by 32 bits, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module swrl_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  swrl_pkg::t_div_req i_req,
    output logic             o_done,
    output logic [63:0]      o_quot,
    output logic [31:0]      o_rem
);
    import swrl_pkg::*;

    logic [63:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_d;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_sh;
    logic [32:0] w_sub;

    assign w_sh  = {r_r, r_q[63]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
            r_q    <= i_req.dividend;
            r_r    <= '0;
            r_d    <= i_req.divisor;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (!w_sub[32]) begin
                r_r <= w_sub[31:0];
                r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_r <= w_sh[31:0];
                r_q <= {r_q[62:0], 1'b0};
            end
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // done pulses once the last quotient bit is in the register
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

>>> rtl/sliding_window_rate_limiter_core.sv
// ---------------------------------------------------------------------------
// sliding_window_rate_limiter_core
// Sliding-window log rate limiter with a sample ring and a shared divider.
// ---------------------------------------------------------------------------
// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tuser=mode, tdata=time,amount
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata=status,wait_us,window_sum
// cfg      in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
// An expire walk runs one divide of the head amount by rate per removed sample;
// a push that paces adds up to two more divide passes.
// Reset is synchronous: queue empty, sum zero, rate 0, window 1.
// Input is ready only in idle; a finished result waits in its own register.
// Config is taken only in idle while no input beat is offered.
module sliding_window_rate_limiter_core #(
    parameter int QUEUE_DEPTH = swrl_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = swrl_pkg::TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [71:0]            s_axis_tdata,  // current_time[39:0], amount[71:40]
    input  logic                   s_axis_tuser,  // mode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [95:0]            m_axis_tdata,  // status[1:0], wait_us[41:2], sum[89:42]
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [7:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    import swrl_pkg::*;
    `include "sliding_window_rate_limiter_core_assert.svh"

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [63:0] TMASK = (TIME_BITS >= 64) ? {64{1'b1}}
                                   : ((64'd1 << TIME_BITS) - 64'd1);
    localparam logic [63:0] WMAX = (64'd1 << 40) - 64'd1;
    localparam logic [47:0] SMAX = {48{1'b1}};

    logic [TIME_BITS-1:0] mem_t [QUEUE_DEPTH];
    logic [31:0]          mem_a [QUEUE_DEPTH];

    t_state r_st, n_st;
    logic [31:0] r_rate;
    logic [7:0]  r_win;
    logic [AW-1:0] r_head, r_tail;
    logic [CW-1:0] r_cnt;
    logic [47:0] r_sum;
    logic        r_mode;
    logic [63:0] r_now;
    logic [31:0] r_amt;
    logic [63:0] r_ht;
    logic [31:0] r_ha;
    logic [TIME_BITS-1:0] r_rdt;
    logic [31:0] r_rda;
    logic [63:0] r_q;
    logic        r_frac;
    logic [1:0]  r_ost;
    logic [39:0] r_owait;
    logic        r_ovld;
    logic [1:0]  r_res_st;
    logic [39:0] r_res_wait;
    logic [47:0] r_res_sum;

    t_div_req w_req;
    logic w_done;
    logic [63:0] w_quot;
    logic [31:0] w_rem;

    swrl_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
                    .o_done(w_done), .o_quot(w_quot), .o_rem(w_rem));

    logic [63:0] w_winl, w_w0, w_lim, w_nsum, w_d;
    logic w_empty, w_full, w_merge, w_exp;
    assign w_winl  = {46'd0, r_win, 10'd0};
    assign w_w0    = r_now - w_winl;
    assign w_lim   = 64'(r_rate) * 64'(r_win);
    assign w_empty = (r_cnt == '0);
    assign w_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign w_merge = !w_empty && (r_ht == r_now)
                     && ({1'b0, r_ha} + {1'b0, r_amt} <= 33'h0_FFFF_FFFF);
    // expiry test once head amount / rate is known
    assign w_exp = (r_ht < w_w0) && ({w_quot[53:0], 10'd0} <= (r_now - r_ht))
                   && (w_quot[63:54] == '0);
    assign w_nsum = ({16'd0, r_sum} + {32'd0, r_amt} > {16'd0, SMAX}) ? {16'd0, SMAX}
                    : {16'd0, r_sum} + {32'd0, r_amt};
    assign w_d = {16'd0, r_sum} - w_lim;

    // head wait
    logic [63:0] w_hd, w_hwait;
    always_comb begin
        w_hwait = '0;
        w_hd = '0;
        if (!w_empty) begin
            if (r_ht >= r_now) begin
                w_hd = r_ht - r_now;
                if (w_hd > WMAX) w_hwait = WMAX;
                else begin
                    w_hd = w_hd + w_winl;
                    w_hwait = (w_hd > (WMAX >> 10)) ? WMAX : {w_hd[53:0], 10'd0};
                end
            end else begin
                w_hd = (w_winl > r_now - r_ht) ? w_winl - (r_now - r_ht) : '0;
                w_hwait = (w_hd > (WMAX >> 10)) ? WMAX : {w_hd[53:0], 10'd0};
            end
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) n_st = S_RD;
            S_RD: begin
                if (r_rate == '0) n_st = r_mode ? S_OUT : S_OUT;
                else if (w_empty) n_st = S_PUSH;
                else n_st = S_RDW;
            end
            // early time: load the head for merge and wait, expire nothing
            S_RDW: n_st = (r_now < w_winl) ? S_PUSH : S_DIVA;
            S_DIVA: if (w_done) n_st = w_exp ? S_EXCHK : S_PUSH;
            S_EXCHK: n_st = S_RD;
            S_PUSH: begin
                if (!r_mode || {16'd0, r_sum} >= w_lim) n_st = S_OUT;
                else if (!w_merge && w_full) n_st = S_OUT;
                else n_st = S_DIVP;
            end
            S_DIVP: n_st = ({16'd0, r_sum} > w_lim) ? S_PACE : S_OUT;
            // saturated quotient skips the fraction pass
            S_PACE: if (w_done) begin
                n_st = (r_frac || w_quot >= 64'd1048576) ? S_OUT : S_PACE;
            end
            S_OUT: if (!r_ovld || m_axis_tready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // divider control
    always_comb begin
        w_req = '0;
        w_req.divisor = r_rate;
        if (r_st == S_RDW && r_now >= w_winl) begin
            w_req.start = 1'b1;
            w_req.dividend = {32'd0, r_rda};
        end else if (r_st == S_DIVP && {16'd0, r_sum} > w_lim) begin
            w_req.start = 1'b1;
            w_req.dividend = w_d;
        end else if (r_st == S_PACE && w_done && !r_frac
                     && w_quot < 64'd1048576) begin
            w_req.start = 1'b1;
            w_req.dividend = {12'd0, w_rem, 20'd0};
        end
    end

    assign s_axis_tready = (r_st == S_IDLE);
    assign o_cfg_ready   = (r_st == S_IDLE) && !s_axis_tvalid;

    always_ff @(posedge i_clk) begin
        r_rdt <= mem_t[r_head];
        r_rda <= mem_a[r_head];
        if (r_st == S_PUSH && r_mode && r_rate != '0 && {16'd0, r_sum} < w_lim) begin
            if (w_merge) mem_a[r_head] <= r_ha + r_amt;
            else if (!w_full) begin
                mem_t[r_tail] <= r_now[TIME_BITS-1:0];
                mem_a[r_tail] <= r_amt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_rate <= '0; r_win <= 8'd1;
            r_head <= '0; r_tail <= '0; r_cnt <= '0; r_sum <= '0;
            r_ovld <= 1'b0; r_frac <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == {7'd0, CFG_RATE}) r_rate <= i_cfg_data;
                else if (i_cfg_index == {7'd0, CFG_WIN}) r_win <= i_cfg_data[7:0];
            end
            // load the result register when it is free or being drained
            if (r_st == S_OUT && (!r_ovld || m_axis_tready)) begin
                r_ovld     <= 1'b1;
                r_res_st   <= r_ost;
                r_res_wait <= r_owait;
                r_res_sum  <= r_sum;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_mode <= s_axis_tuser;
                    r_now  <= {24'd0, s_axis_tdata[39:0]} & TMASK;
                    r_amt  <= s_axis_tdata[71:40];
                    r_ost  <= s_axis_tuser ? ST_ACCEPT : ST_EXPIRE;
                    r_owait <= '0;
                end
                S_RD: ;
                S_RDW: begin
                    r_ht <= 64'(r_rdt);
                    r_ha <= r_rda;
                end
                S_DIVA: ;
                S_EXCHK: begin
                    // drop the head sample
                    r_sum  <= (r_sum >= {16'd0, r_ha}) ? r_sum - {16'd0, r_ha} : '0;
                    r_head <= (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    r_cnt  <= r_cnt - 1'b1;
                end
                S_PUSH: begin
                    r_frac <= 1'b0;
                    if (r_mode) begin
                        if ({16'd0, r_sum} >= w_lim) begin
                            r_ost <= ST_WAIT;
                            r_owait <= w_hwait[39:0];
                        end else if (!w_merge && w_full) begin
                            r_ost <= ST_FULL;
                        end else begin
                            if (!w_merge) begin
                                r_tail <= (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0
                                          : r_tail + 1'b1;
                                r_cnt  <= r_cnt + 1'b1;
                            end
                            r_sum <= w_nsum[47:0];
                        end
                    end
                end
                S_DIVP: ;
                S_PACE: if (w_done) begin
                    if (!r_frac) begin
                        r_frac <= 1'b1;
                        r_q <= w_quot;
                        if (w_quot >= 64'd1048576) r_owait <= WMAX[39:0];
                    end else begin
                        r_owait <= ((r_q << 20) + w_quot > WMAX) ? WMAX[39:0]
                                   : 40'((r_q << 20) + w_quot);
                    end
                end
                S_OUT: ;
                default: ;
            endcase
            // bypass: rate zero goes straight to output
            if (r_st == S_RD && r_rate == '0) r_owait <= '0;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {6'd0, r_res_sum, r_res_wait, r_res_st};

    `SWRL_ASSERT_IMP(a_rdy_idle, i_clk, i_rst_n, s_axis_tready, r_st == S_IDLE)
    `SWRL_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(QUEUE_DEPTH))
    `SWRL_ASSERT_NXT(a_acc_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
                     !s_axis_tready)
endmodule
